[sv/dotq_pkg.sv]
`timescale 1ns / 1ps

package dotq_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int ID_W        = 4;
  localparam int DL_W        = 64;
  localparam int STEP_W      = 20;
  localparam int DELAY_W     = 31;
  localparam int PROD_W      = 41;
  localparam int MAX_FIRED   = 16;
  localparam int FIRE_W      = $clog2(MAX_FIRED);
  localparam int US_PER_MS   = 1000;
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1000);

  typedef enum logic [1:0] {
    MODE_SCHEDULE   = 2'd0,
    MODE_RESCHEDULE = 2'd1,
    MODE_CANCEL     = 2'd2,
    MODE_TICK       = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE,
    OP_POP
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_INSERT,
    S_CANCEL,
    S_STEP,
    S_DRAIN
  } state_e;

  typedef struct packed {
    mode_e              mode;
    logic [ID_W-1:0]    entry_id;
    logic [DELAY_W-1:0] wait_ms;
  } in_t;

  typedef struct packed {
    logic [ID_W-1:0] fired_entry;
    logic            last;
  } out_t;

  // one armed timer held by a cell
  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] id;
    logic [DL_W-1:0] dl;
  } slot_t;

  // operation broadcast to every cell of the chain
  typedef struct packed {
    op_e             op;
    logic [ID_W-1:0] id;
    logic [DL_W-1:0] dl;
  } cell_ctrl_t;

endpackage

[sv/dotq_cell.sv]
`timescale 1ns / 1ps

module dotq_cell
  import dotq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  slot_t      left_i,
  input  slot_t      right_i,
  input  logic       left_gt_i,
  input  logic       left_shift_i,
  output slot_t      slot_o,
  output logic       gt_o,
  output logic       shift_o
);

  slot_t slot_q, slot_d;
  logic  match;

  // new deadline goes in front of this cell; strict compare keeps fifo order on ties
  assign gt_o    = !slot_q.valid || (slot_q.dl > ctrl_i.dl);
  assign match   = slot_q.valid && (slot_q.id == ctrl_i.id);
  assign shift_o = left_shift_i || match;
  assign slot_o  = slot_q;

  always_comb begin
    slot_d = slot_q;
    case (ctrl_i.op)
      OP_INSERT: begin
        if (gt_o) begin
          if (left_gt_i) begin
            slot_d = left_i;
          end else begin
            slot_d.valid = 1'b1;
            slot_d.id    = ctrl_i.id;
            slot_d.dl    = ctrl_i.dl;
          end
        end
      end
      OP_REMOVE: begin
        if (shift_o) begin
          slot_d = right_i;
        end
      end
      OP_POP: begin
        slot_d = right_i;
      end
      default: begin
        slot_d = slot_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

endmodule

[sv/deadline_ordered_timer_queue.sv]
`timescale 1ns / 1ps
// channel   | signals                              | beat
// ----------+--------------------------------------+-------------------------------
// in        | in_valid_i, in_ready_o, in_data_i    | one command (in_t)
// out       | out_valid_o, out_ready_i, out_data_o | one fired entry (out_t)
// cfg       | cfg_we_i, cfg_wdata_i                | us_per_tick, taken at once
//
// one command at a time; in_ready_o is high only while the controller is idle
// schedule and reschedule step through accept, multiply, add and insert; schedule
// skips the insert when it finds the entry already armed; cancel is accept, remove
// tick steps through accept and clock step, then drains, popping the due head of the cell
// chain for each fired entry and returning to idle when nothing is due
// out stalls only hold the drain; a result waiting in the output register does not block
// reset empties the chain at once, clock to zero, us_per_tick to 1000

module deadline_ordered_timer_queue
  import dotq_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_t               in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_t              out_data_o,
  input  logic              cfg_we_i,
  input  logic [STEP_W-1:0] cfg_wdata_i
);

  state_e            state_q, state_d;
  in_t               cmd_q, cmd_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [DL_W-1:0]   new_dl_q, new_dl_d;
  logic [DL_W-1:0]   now_q, now_d;
  logic [STEP_W-1:0] step_q;
  logic [FIRE_W-1:0] fire_cnt_q, fire_cnt_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_q, out_d;

  cell_ctrl_t        ctrl;
  slot_t             slots   [ENTRIES];
  slot_t             right_s [ENTRIES];
  slot_t             left_s  [ENTRIES];
  logic              gt      [ENTRIES];
  logic              shift   [ENTRIES];
  logic              left_gt [ENTRIES];
  logic              left_sh [ENTRIES];
  logic [ENTRIES-1:0] any_match;
  logic              armed;
  logic              head_due, next_due, out_free, accept;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_s[i]  = '0;
      assign left_gt[i] = 1'b0;
      assign left_sh[i] = 1'b0;
    end else begin : g_mid
      assign left_s[i]  = slots[i-1];
      assign left_gt[i] = gt[i-1];
      assign left_sh[i] = shift[i-1];
    end
    if (i == ENTRIES - 1) begin : g_last
      assign right_s[i] = '0;
    end else begin : g_inner
      assign right_s[i] = slots[i+1];
    end
    assign any_match[i] = slots[i].valid && (slots[i].id == cmd_q.entry_id);

    dotq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .left_i      (left_s[i]),
      .right_i     (right_s[i]),
      .left_gt_i   (left_gt[i]),
      .left_shift_i(left_sh[i]),
      .slot_o      (slots[i]),
      .gt_o        (gt[i]),
      .shift_o     (shift[i])
    );
  end

  assign armed      = |any_match;
  assign head_due   = slots[0].valid && (slots[0].dl <= now_q);
  assign next_due   = slots[1].valid && (slots[1].dl <= now_q);
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    prod_d      = prod_q;
    new_dl_d    = new_dl_q;
    now_d       = now_q;
    fire_cnt_d  = fire_cnt_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ctrl.op     = OP_HOLD;
    ctrl.id     = cmd_q.entry_id;
    ctrl.dl     = new_dl_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d = in_data_i;
          if (in_data_i.mode == MODE_TICK) begin
            state_d = S_STEP;
          end else if (32'(in_data_i.entry_id) < ENTRIES) begin
            if (in_data_i.mode == MODE_CANCEL) begin
              state_d = S_CANCEL;
            end else begin
              state_d = S_MUL;
            end
          end
        end
      end
      S_MUL: begin
        prod_d  = PROD_W'(cmd_q.wait_ms) * PROD_W'(US_PER_MS);
        state_d = S_ADD;
      end
      S_ADD: begin
        new_dl_d = now_q + DL_W'(prod_q);
        if (cmd_q.mode == MODE_RESCHEDULE) begin
          ctrl.op = OP_REMOVE;
          state_d = S_INSERT;
        end else if (armed) begin
          // already armed: existing deadline stands
          state_d = S_IDLE;
        end else begin
          state_d = S_INSERT;
        end
      end
      S_INSERT: begin
        ctrl.op = OP_INSERT;
        state_d = S_IDLE;
      end
      S_CANCEL: begin
        ctrl.op = OP_REMOVE;
        state_d = S_IDLE;
      end
      S_STEP: begin
        now_d      = now_q + DL_W'(step_q);
        fire_cnt_d = '0;
        state_d    = S_DRAIN;
      end
      S_DRAIN: begin
        if (!head_due) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          ctrl.op               = OP_POP;
          out_valid_d           = 1'b1;
          out_d.fired_entry     = slots[0].id;
          out_d.last            = !next_due || (fire_cnt_q == FIRE_W'(MAX_FIRED - 1));
          fire_cnt_d            = fire_cnt_q + FIRE_W'(1);
          if (out_d.last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      now_q       <= '0;
      step_q      <= STEP_RESET;
      fire_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      now_q       <= now_d;
      fire_cnt_q  <= fire_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        step_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    prod_q   <= prod_d;
    new_dl_q <= new_dl_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
